>>> sv/itrc_pkg.sv
// Shared types and constants for the interval timing rate converter.
package itrc_pkg;

   localparam int WordW = 32;
   localparam int RateW = 20;
   localparam logic [RateW-1:0] DevRateReset = RateW'(48000);

   typedef struct packed {
      logic             ok;
      logic             same_rate;
      logic [WordW-1:0] len;
      logic [WordW-1:0] pos;
      logic [RateW-1:0] src;
      logic [RateW-1:0] dev;
   } job_type;

endpackage

>>> sv/interval_timing_rate_convert_top.sv
// Top level of the interval timing rate converter.
// Each item's interval length and position are rescaled from the source rate to the
// device rate with rounding, L*dev/src saturated to 32 bits, the position first reduced
// modulo the length and clamped below the result length. For a valid item one shared
// restoring divider does a 52-step modulo and two 52-step divisions, one bit per cycle,
// each division followed by a read-out of the quotient; the back end takes no new item
// until it has finished the last. An item that is invalid on arrival skips the divider
// and goes from the front register through the DONE state into the output register.
// A front register takes the next item while the back end works, and an output
// register holds a finished result while the receiver stalls.
module interval_timing_rate_convert_top
   import itrc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_connected,
   input  logic             req_remote_valid,
   input  logic [WordW-1:0] req_remote_length,
   input  logic [WordW-1:0] req_remote_position,
   input  logic [RateW-1:0] req_source_rate,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_valid_res,
   output logic [WordW-1:0] rsp_device_length,
   output logic [WordW-1:0] rsp_device_position,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [RateW-1:0] csr_device_rate
);
   logic [RateW-1:0] dev_rate_ff;
   logic             job_valid, job_stall;
   job_type          job;

   // The rate register is always writable.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_rate_ff <= DevRateReset;
      end else if (csr_valid) begin
         dev_rate_ff <= csr_device_rate;
      end
   end

   itrc_front u_front (
      .clock, .reset, .req_valid, .req_stall,
      .connected(req_connected), .remote_valid(req_remote_valid),
      .remote_length(req_remote_length), .remote_position(req_remote_position),
      .source_rate(req_source_rate), .dev_rate(dev_rate_ff),
      .job_valid, .job_stall, .job);

   itrc_back u_back (
      .clock, .reset, .job_valid, .job_stall, .job,
      .rsp_valid, .rsp_stall, .valid_res(rsp_valid_res),
      .device_length(rsp_device_length), .device_position(rsp_device_position));
endmodule

>>> sv/itrc_front.sv
// Front end: accepts items, checks validity and captures the rate.
module itrc_front
   import itrc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             connected,
   input  logic             remote_valid,
   input  logic [WordW-1:0] remote_length,
   input  logic [WordW-1:0] remote_position,
   input  logic [RateW-1:0] source_rate,
   input  logic [RateW-1:0] dev_rate,
   output logic             job_valid,
   input  logic             job_stall,
   output job_type          job
);
   logic    full_ff, full_in;
   job_type job_ff, job_in;
   logic    take;

   assign req_stall = full_ff & job_stall;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      job_in.ok = connected & remote_valid & (remote_length != '0) &
                  (source_rate != '0) & (dev_rate != '0);
      job_in.same_rate = (source_rate == dev_rate);
      job_in.len = remote_length;
      job_in.pos = remote_position;
      job_in.src = source_rate;
      job_in.dev = dev_rate;
      full_in = take | (full_ff & job_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      if (take) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = full_ff;
   assign job       = job_ff;
endmodule

>>> sv/itrc_back.sv
// Back end: modulo, scaling and rounding divisions, clamp, output register.
module itrc_back
   import itrc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_stall,
   input  job_type          job,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             valid_res,
   output logic [WordW-1:0] device_length,
   output logic [WordW-1:0] device_position
);
   localparam int ProdW = WordW + RateW;
   localparam int CntW  = $clog2(ProdW + 1);

   typedef enum logic [2:0] {
      IDLE, MODL, SCLL, DIVL, SCLP, DIVP, DONE
   } state_type;

   state_type        state_ff;
   job_type          job_ff;
   logic [ProdW-1:0] num_ff;
   logic [ProdW:0]   rem_ff;
   logic [ProdW-1:0] quo_ff;
   logic [CntW-1:0]  cnt_ff;
   logic [WordW-1:0] pmod_ff;
   logic [WordW-1:0] dlen_ff;
   logic             out_v_ff, res_v_ff;
   logic [WordW-1:0] out_len_ff, out_pos_ff;

   logic [ProdW:0]   rem_sh;
   logic [ProdW:0]   dvs;
   logic             ge;
   logic [WordW-1:0] sat_q;
   logic [ProdW:0]   rem_in;
   logic [ProdW-1:0] quo_in;

   assign job_stall = (state_ff != IDLE);
   // One restoring step; divisor is the length for modulo, else the rate.
   assign dvs    = (state_ff == MODL) ? (ProdW+1)'(job_ff.len) : (ProdW+1)'(job_ff.src);
   assign rem_sh = {rem_ff[ProdW-1:0], num_ff[ProdW-1]};
   assign ge     = rem_sh >= dvs;
   assign rem_in = ge ? rem_sh - dvs : rem_sh;
   assign quo_in = {quo_ff[ProdW-2:0], ge};
   assign sat_q  = (quo_ff[ProdW-1:WordW] != '0) ? '1 : quo_ff[WordW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         out_v_ff <= 1'b0;
      end else begin
         // In DONE the output register is refilled below when it frees up.
         if (rsp_valid & ~rsp_stall & (state_ff != DONE)) out_v_ff <= 1'b0;
         case (state_ff)
            IDLE: if (job_valid) begin
               job_ff <= job;
               if (!job.ok) begin
                  dlen_ff <= '0;
                  state_ff <= DONE;
               end else begin
                  num_ff <= ProdW'(job.pos);
                  rem_ff <= '0;
                  cnt_ff <= CntW'(ProdW);
                  state_ff <= MODL;
               end
            end
            MODL: begin
               rem_ff <= rem_in; num_ff <= num_ff << 1; cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CntW'(1)) begin
                  pmod_ff <= rem_in[WordW-1:0];
                  state_ff <= SCLL;
               end
            end
            SCLL: begin
               num_ff <= ProdW'(job_ff.len) * ProdW'(job_ff.dev) +
                         ProdW'(job_ff.src >> 1);
               rem_ff <= '0; quo_ff <= '0; cnt_ff <= CntW'(ProdW);
               state_ff <= DIVL;
            end
            DIVL: begin
               rem_ff <= rem_in; quo_ff <= quo_in;
               num_ff <= num_ff << 1; cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  dlen_ff <= job_ff.same_rate ? job_ff.len : sat_q;
                  state_ff <= SCLP;
               end
            end
            SCLP: begin
               num_ff <= ProdW'(pmod_ff) * ProdW'(job_ff.dev) +
                         ProdW'(job_ff.src >> 1);
               rem_ff <= '0; quo_ff <= '0; cnt_ff <= CntW'(ProdW);
               state_ff <= DIVP;
            end
            DIVP: begin
               rem_ff <= rem_in; quo_ff <= quo_in;
               num_ff <= num_ff << 1; cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  pmod_ff <= job_ff.same_rate ? pmod_ff : sat_q;
                  state_ff <= DONE;
               end
            end
            DONE: if (!out_v_ff || !rsp_stall) begin
               out_v_ff <= 1'b1;
               res_v_ff <= job_ff.ok & (dlen_ff != '0);
               out_len_ff <= (job_ff.ok & (dlen_ff != '0)) ? dlen_ff : '0;
               out_pos_ff <= ~(job_ff.ok & (dlen_ff != '0)) ? '0 :
                             (pmod_ff > dlen_ff - 1'b1) ? dlen_ff - 1'b1 : pmod_ff;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid       = out_v_ff;
   assign valid_res       = res_v_ff;
   assign device_length   = out_len_ff;
   assign device_position = out_pos_ff;

   a_pos_below: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid & valid_res) |-> (device_position < device_length))
      else $error("position not below length");
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid & ~valid_res) |-> (device_length == '0 && device_position == '0))
      else $error("invalid result not zeroed");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid & rsp_stall) |-> (rsp_valid && $stable(device_length)))
      else $error("stalled result changed");
endmodule
